/* sv/spq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Default sizes of the slot row
  localparam int unsigned SPQ_DEPTH      = 16;
  localparam int unsigned SPQ_VALUE_BITS = 32;

  // Operation codes
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EMPTY_DEQ  = 2'd1;
  localparam logic [1:0] ST_FULL_DROP  = 2'd2;

  // One request
  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        entry_value;
    logic signed [31:0] entry_priority;
  } spq_in_t;

  // One result
  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        removed_value;
    logic signed [31:0] removed_priority;
    logic               head_valid;
    logic [31:0]        head_value;
    logic signed [31:0] head_priority;
    logic [4:0]         occupancy;
  } spq_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } spq_cmd_t;

endpackage

`default_nettype wire

/* sv/sorted_priority_queue_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Valid        Ready        Payload
// request   in_valid_i   in_ready_o   in_data_i  (spq_in_t)
// result    out_valid_o  out_ready_i  out_data_o (spq_out_t)
//
// Each request is first taken in; then the slot row compares every slot in
// parallel and shifts, loading the result register.
// A new request is taken while the previous result still waits in that register.
// Execution stalls while the result register is full and not being drained.
// Reset empties the queue at once; slot contents are not cleared.

module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH      = SPQ_DEPTH,
  parameter int unsigned VALUE_BITS = SPQ_VALUE_BITS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire spq_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output spq_out_t      out_data_o
);

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  spq_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

/* sv/spq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output spq_cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequence one request: take it in, then execute once the result slot is free
  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.execute = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result valid until its transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_exec_only_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |-> state_q == ST_EXEC)
    else $error("execute issued outside the execute state");

  a_result_follows_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.execute))
    else $error("result valid raised without an execute");
`endif

endmodule

`default_nettype wire

/* sv/spq_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH      = SPQ_DEPTH,
  parameter int unsigned VALUE_BITS = SPQ_VALUE_BITS
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire spq_cmd_t cmd_i,
  input  wire spq_in_t  in_data_i,
  output spq_out_t      out_data_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  spq_in_t req_q;
  spq_out_t res_q, res_d;

  logic [VALUE_BITS-1:0] val_q [DEPTH];
  logic signed [31:0]    pri_q [DEPTH];
  logic [VALUE_BITS-1:0] prev_val [DEPTH];
  logic signed [31:0]    prev_pri [DEPTH];
  logic [VALUE_BITS-1:0] next_val [DEPTH];
  logic signed [31:0]    next_pri [DEPTH];
  logic [DEPTH-1:0]      gt;
  logic [DEPTH-1:0]      from_below;
  logic [DEPTH-1:0]      take;

  logic [CW-1:0]         count_q, count_d;
  logic [VALUE_BITS-1:0] new_val;
  logic signed [31:0]    new_pri;
  logic                  full;
  logic                  empty;

  assign new_val = VALUE_BITS'(req_q.entry_value);
  assign new_pri = req_q.entry_priority;
  assign full    = (count_q == CW'(DEPTH));
  assign empty   = (count_q == '0);

  // Hold the request while it executes
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_data_i;
    end
  end

  // Compare every occupied slot against the new priority at once
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    assign gt[i]   = (count_q > CW'(i)) && (pri_q[i] > new_pri);
    assign take[i] = gt[i] || (count_q == CW'(i));

    if (i == 0) begin : g_first
      assign from_below[i] = 1'b0;
      assign prev_val[i]   = val_q[i];
      assign prev_pri[i]   = pri_q[i];
    end else begin : g_rest
      assign from_below[i] = gt[i-1];
      assign prev_val[i]   = val_q[i-1];
      assign prev_pri[i]   = pri_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_val[i] = val_q[i];
      assign next_pri[i] = pri_q[i];
    end else begin : g_inner
      assign next_val[i] = val_q[i+1];
      assign next_pri[i] = pri_q[i+1];
    end

    // Shift up on insert, shift down on removal
    always_ff @(posedge clk_i) begin
      if (cmd_i.execute) begin
        case (req_q.op)
          OP_ENQUEUE: begin
            if (!full) begin
              if (from_below[i]) begin
                val_q[i] <= prev_val[i];
                pri_q[i] <= prev_pri[i];
              end else if (take[i]) begin
                val_q[i] <= new_val;
                pri_q[i] <= new_pri;
              end
            end
          end
          OP_DEQUEUE: begin
            if (!empty) begin
              val_q[i] <= next_val[i];
              pri_q[i] <= next_pri[i];
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Work out the result and the new occupancy
  always_comb begin
    count_d                = count_q;
    res_d                  = '0;
    res_d.status           = ST_OK;
    res_d.head_value       = 32'(val_q[0]);
    res_d.head_priority    = pri_q[0];
    case (req_q.op)
      OP_ENQUEUE: begin
        if (full) begin
          res_d.status = ST_FULL_DROP;
        end else begin
          count_d = count_q + CW'(1);
          if (take[0]) begin
            res_d.head_value    = 32'(new_val);
            res_d.head_priority = new_pri;
          end
        end
      end
      OP_DEQUEUE: begin
        if (empty) begin
          res_d.status = ST_EMPTY_DEQ;
        end else begin
          count_d                = count_q - CW'(1);
          res_d.removed_value    = 32'(val_q[0]);
          res_d.removed_priority = pri_q[0];
          res_d.head_value       = 32'(val_q[1]);
          res_d.head_priority    = pri_q[1];
        end
      end
      OP_CLEAR: count_d = '0;
      default: ;
    endcase
    res_d.head_valid = (count_d != '0);
    if (count_d == '0) begin
      res_d.head_value    = '0;
      res_d.head_priority = '0;
    end
    res_d.occupancy = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      res_q <= res_d;
    end
  end

  assign out_data_o = res_q;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy beyond the slot row");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CW'(2) |-> pri_q[0] <= pri_q[1])
    else $error("head slot out of priority order");
`endif

endmodule

`default_nettype wire
